// File: design/gfr_pkg.sv
// ----------------------------------------------------------------------------
// gfr_pkg: shared types and constants of the gain fade ramp
// Field widths, operation codes, sequencer states and the raised cosine
// table generator.
// ----------------------------------------------------------------------------
package gfr_pkg;

  localparam int GAIN_W = 17;  // Q1.16 gains
  localparam int TIME_W = 24;  // Q8.16 seconds
  localparam int RATE_W = 26;  // Q10.16 time scale
  localparam int FRAC_W = 16;

  localparam int COS_TABLE_DEPTH = 256;
  localparam int IDX_W = $clog2(COS_TABLE_DEPTH + 1);
  // progress (at most unity) times the table depth; integer part is IDX_W bits
  localparam int POS_W = FRAC_W + IDX_W;

  localparam int INC_W   = RATE_W + TIME_W - FRAC_W;
  localparam int SUM_W   = INC_W + 1;
  localparam int LERP_W  = GAIN_W + FRAC_W;
  localparam int BLEND_W = 2 * GAIN_W + 1;

  localparam int MUL_STEPS  = TIME_W;
  localparam int RDIV_STEPS = 33;
  localparam int PDIV_STEPS = FRAC_W;
  localparam int CNT_W      = $clog2(RDIV_STEPS);

  localparam int CFG_ADDR_W  = 3;
  localparam int REG_SEL_BIT = 2;

  localparam logic [GAIN_W-1:0]  ONE_Q16       = 17'd65536;
  localparam logic [GAIN_W-1:0]  FADE_MIN_DIFF = 17'd66;       // 0.001 in Q1.16
  localparam logic [RATE_W-1:0]  RATE_UNITY    = 26'd65536;
  localparam logic [RATE_W-1:0]  RATE_MAX      = 26'd65075262; // 2^32 / 66
  localparam logic [BLEND_W-1:0] HALF_LSB      = 35'd32768;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  localparam logic [1:0] CURVE_NONE   = 2'd0;
  localparam logic [1:0] CURVE_LINEAR = 2'd1;
  localparam logic [1:0] CURVE_COSINE = 2'd2;

  localparam logic REG_FADE_LENGTH = 1'b0;
  localparam logic REG_CURVE_KIND  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_TICK,
    ST_RDIV,
    ST_GAIN,
    ST_PDIV,
    ST_POS,
    ST_TAB,
    ST_INTERP,
    ST_BLEND,
    ST_SUM,
    ST_OUT
  } state_t;

  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  // 1 - min(1, t) in Q30
  function automatic logic [63:0] one_minus(input logic [63:0] t);
    return (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
  endfunction

  // Raised cosine at point i of the first half, Q16, from a Taylor series
  function automatic logic [GAIN_W-1:0] rc_half(input int unsigned i);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] r;
    a  = (PI_Q30 * 64'(i)) / 64'(COS_TABLE_DEPTH);
    a2 = (a * a) >> 30;
    r  = ONE_Q30;
    r  = one_minus(((a2 * r) >> 30) / 64'd132);
    r  = one_minus(((a2 * r) >> 30) / 64'd90);
    r  = one_minus(((a2 * r) >> 30) / 64'd56);
    r  = one_minus(((a2 * r) >> 30) / 64'd30);
    r  = one_minus(((a2 * r) >> 30) / 64'd12);
    r  = one_minus(((a2 * r) >> 30) / 64'd2);
    return GAIN_W'(((ONE_Q30 - r) + 64'd16384) >> 15);
  endfunction

  // Table point i of 0..COS_TABLE_DEPTH; the upper half mirrors the lower
  function automatic logic [GAIN_W-1:0] cos_point(input int unsigned i);
    if (2 * i <= COS_TABLE_DEPTH) begin
      return rc_half(i);
    end
    return ONE_Q16 - rc_half(COS_TABLE_DEPTH - i);
  endfunction

endpackage

// File: design/gain_fade_ramp_top.sv
// ----------------------------------------------------------------------------
// gain_fade_ramp_top: gain fade generator with none, linear or cosine curve
// Sequence: each item is decoded; a tick while fading first runs the serial
//   multiply, and a start that begins a fade runs the reciprocal divide.
//   While a fade runs, the progress divide (skipped at full progress) and
//   the weight and blend steps follow; otherwise the end gain is reported.
// New items stall until the last result is in the output register, as the
//   divider and multiplier are shared. Synchronous active-low reset.
// ----------------------------------------------------------------------------
module gain_fade_ramp_top
  import gfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_mode,
  input  logic [TIME_W-1:0]     in_dt,
  input  logic [GAIN_W-1:0]     in_from_gain,
  input  logic [GAIN_W-1:0]     in_to_gain,
  input  logic [GAIN_W-1:0]     in_set_gain,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [GAIN_W-1:0]     out_current_gain,
  output logic                  out_fade_done,
  output logic                  out_is_fading,
  output logic [GAIN_W-1:0]     out_target_gain,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t state_r, state_nxt;

  // configuration
  logic [TIME_W-1:0] fade_length_r;
  logic [1:0]        curve_kind_r;

  // fade state
  logic [GAIN_W-1:0] start_level_r, start_level_nxt;
  logic [GAIN_W-1:0] end_level_r, end_level_nxt;
  logic [TIME_W-1:0] elapsed_r, elapsed_nxt;
  logic [RATE_W-1:0] rate_scale_r, rate_scale_nxt;
  logic              active_r, active_nxt;
  logic              done_r, done_nxt;

  // captured item
  logic [1:0]        mode_r, mode_nxt;
  logic [TIME_W-1:0] dt_r, dt_nxt;       // shifts right during the multiply
  logic [GAIN_W-1:0] from_r, from_nxt;
  logic [GAIN_W-1:0] to_r, to_nxt;
  logic [GAIN_W-1:0] set_r, set_nxt;

  // serial multiply and shared serial divider
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [RATE_W-1:0] acc_r, acc_nxt;
  logic [TIME_W-1:0] plo_r, plo_nxt;
  logic [TIME_W-1:0] div_rem_r, div_rem_nxt;
  logic [TIME_W-1:0] divisor_r, divisor_nxt;
  logic [RATE_W-1:0] div_q_r, div_q_nxt;

  // weight and blend pipeline
  logic [GAIN_W-1:0] p_r, p_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [GAIN_W-1:0] lo_r, lo_nxt;
  logic [GAIN_W-1:0] hi_r, hi_nxt;
  logic              sat_r, sat_nxt;
  logic [GAIN_W-1:0] w_r, w_nxt;
  logic              up_r, up_nxt;
  logic [GAIN_W-1:0] m_r, m_nxt;
  logic [GAIN_W-1:0] cur_r, cur_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [GAIN_W-1:0] out_gain_r, out_gain_nxt;
  logic              out_done_r, out_done_nxt;
  logic              out_fading_r, out_fading_nxt;
  logic [GAIN_W-1:0] out_target_r, out_target_nxt;

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic in_xfer;
  logic out_free;

  // Take a new item only when the sequencer is idle; a finished result may
  // still sit in the output register waiting for its transfer.
  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_current_gain = out_gain_r;
  assign out_fade_done    = out_done_r;
  assign out_is_fading    = out_fading_r;
  assign out_target_gain  = out_target_r;

  // --------------------------------------------------------------------------
  // Configuration port: registers at 4*i, decoded on one address bit
  // --------------------------------------------------------------------------
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_length_r <= '0;
      curve_kind_r  <= CURVE_NONE;
    end else if (cfg_wr) begin
      unique case (paddr[REG_SEL_BIT])
        REG_FADE_LENGTH: fade_length_r <= pwdata[TIME_W-1:0];
        REG_CURVE_KIND:  curve_kind_r  <= pwdata[1:0];
        default:         fade_length_r <= fade_length_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[REG_SEL_BIT])
      REG_FADE_LENGTH: prdata = 32'(fade_length_r);
      REG_CURVE_KIND:  prdata = 32'(curve_kind_r);
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Raised cosine table, constant points folded at elaboration
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0] cos_tab [COS_TABLE_DEPTH+1];

  for (genvar gi = 0; gi <= COS_TABLE_DEPTH; gi++) begin : g_cos_tab
    assign cos_tab[gi] = cos_point(gi);
  end

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0]  gain_diff;
  logic               fade_small;
  logic [RATE_W:0]    mul_sum;
  logic [INC_W-1:0]   inc;
  logic [SUM_W-1:0]   tick_sum;
  logic               tick_end;
  logic               div_bit;
  logic [TIME_W:0]    rem_sh;
  logic               div_ge;
  logic [TIME_W:0]    div_diff;
  logic [TIME_W-1:0]  rem_next;
  logic [RATE_W-1:0]  q_next;
  logic               prog_full;
  logic               mul_last;
  logic               rdiv_last;
  logic               pdiv_last;
  logic [IDX_W-1:0]   tab_idx;
  logic               tab_sat;
  logic [IDX_W-1:0]   lo_idx;
  logic [IDX_W-1:0]   hi_idx;
  logic [LERP_W-1:0]  lerp_prod;
  logic [GAIN_W-1:0]  lerp;
  logic [GAIN_W-1:0]  mag;
  logic [BLEND_W-1:0] blend_prod;

  // Start: distance between the two gains; under 0.001 means no fade.
  assign gain_diff  = (from_r > to_r) ? from_r - to_r : to_r - from_r;
  assign fade_small = gain_diff < FADE_MIN_DIFF;

  // Serial multiply dt * rate_scale, LSB of dt first: add, then shift the
  // low product bit out into plo_r.
  assign mul_sum  = {1'b0, acc_r} + (dt_r[0] ? {1'b0, rate_scale_r} : '0);
  assign inc      = {acc_r, plo_r[TIME_W-1:FRAC_W]};
  assign tick_sum = SUM_W'(elapsed_r) + SUM_W'(inc);
  assign tick_end = tick_sum >= SUM_W'(fade_length_r);

  // Shared restoring divider, one quotient bit a cycle. The reciprocal feeds
  // the dividend 2^32 (a one, then zeros); progress feeds zeros after a
  // remainder preloaded with elapsed.
  assign div_bit  = (state_r == ST_RDIV) && (cnt_r == '0);
  assign rem_sh   = {div_rem_r, div_bit};
  assign div_ge   = rem_sh >= {1'b0, divisor_r};
  assign div_diff = rem_sh - {1'b0, divisor_r};
  assign rem_next = div_ge ? div_diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
  assign q_next   = {div_q_r[RATE_W-2:0], div_ge};

  assign mul_last  = (cnt_r == CNT_W'(MUL_STEPS - 1));
  assign rdiv_last = (cnt_r == CNT_W'(RDIV_STEPS - 1));
  assign pdiv_last = (cnt_r == CNT_W'(PDIV_STEPS - 1));

  // Progress is full when the length is zero or already reached.
  assign prog_full = (fade_length_r == '0) || (elapsed_r >= fade_length_r);

  // Table position: integer part picks the pair of points, low 16 bits
  // interpolate between them.
  assign tab_idx   = pos_r[POS_W-1:FRAC_W];
  assign tab_sat   = tab_idx >= IDX_W'(COS_TABLE_DEPTH);
  assign lo_idx    = tab_sat ? IDX_W'(COS_TABLE_DEPTH) : tab_idx;
  assign hi_idx    = tab_sat ? IDX_W'(COS_TABLE_DEPTH) : tab_idx + 1'b1;
  assign lerp_prod = LERP_W'(hi_r - lo_r) * LERP_W'(pos_r[FRAC_W-1:0]);
  assign lerp      = lo_r + lerp_prod[LERP_W-1:FRAC_W];

  // Blend magnitude, rounded half up, applied toward the end gain.
  assign mag        = up_r ? end_level_r - start_level_r : start_level_r - end_level_r;
  assign blend_prod = BLEND_W'(mag) * BLEND_W'(w_r) + HALF_LSB;

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (mode_r)
          MODE_TICK:  state_nxt = active_r ? ST_MUL : ST_GAIN;
          MODE_START: state_nxt = fade_small ? ST_GAIN : ST_RDIV;
          default:    state_nxt = ST_GAIN;
        endcase
      end
      ST_MUL: begin
        if (mul_last) state_nxt = ST_TICK;
      end
      ST_TICK: state_nxt = ST_GAIN;
      ST_RDIV: begin
        if (rdiv_last) state_nxt = ST_GAIN;
      end
      ST_GAIN: begin
        priority if (!active_r) state_nxt = ST_OUT;
        else if (prog_full)     state_nxt = ST_POS;
        else                    state_nxt = ST_PDIV;
      end
      ST_PDIV: begin
        if (pdiv_last) state_nxt = ST_POS;
      end
      ST_POS:    state_nxt = ST_TAB;
      ST_TAB:    state_nxt = ST_INTERP;
      ST_INTERP: state_nxt = ST_BLEND;
      ST_BLEND:  state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: datapath controls and next values
  // --------------------------------------------------------------------------
  always_comb begin
    start_level_nxt = start_level_r;
    end_level_nxt   = end_level_r;
    elapsed_nxt     = elapsed_r;
    rate_scale_nxt  = rate_scale_r;
    active_nxt      = active_r;
    done_nxt        = done_r;
    mode_nxt        = mode_r;
    dt_nxt          = dt_r;
    from_nxt        = from_r;
    to_nxt          = to_r;
    set_nxt         = set_r;
    cnt_nxt         = cnt_r;
    acc_nxt         = acc_r;
    plo_nxt         = plo_r;
    div_rem_nxt     = div_rem_r;
    divisor_nxt     = divisor_r;
    div_q_nxt       = div_q_r;
    p_nxt           = p_r;
    pos_nxt         = pos_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    sat_nxt         = sat_r;
    w_nxt           = w_r;
    up_nxt          = up_r;
    m_nxt           = m_r;
    cur_nxt         = cur_r;
    // drop the held result once its transfer completes
    out_valid_nxt   = out_valid_r && out_stall;
    out_gain_nxt    = out_gain_r;
    out_done_nxt    = out_done_r;
    out_fading_nxt  = out_fading_r;
    out_target_nxt  = out_target_r;

    unique case (state_r)
      ST_IDLE: begin
        // capture the whole item on its transfer
        if (in_xfer) begin
          mode_nxt = in_mode;
          dt_nxt   = in_dt;
          from_nxt = in_from_gain;
          to_nxt   = in_to_gain;
          set_nxt  = in_set_gain;
        end
      end
      ST_DECODE: begin
        done_nxt = 1'b0;
        cnt_nxt  = '0;
        unique case (mode_r)
          MODE_TICK: begin
            acc_nxt = '0;
            plo_nxt = '0;
          end
          MODE_START: begin
            start_level_nxt = from_r;
            end_level_nxt   = to_r;
            elapsed_nxt     = '0;
            if (fade_small) begin
              active_nxt     = 1'b0;
              rate_scale_nxt = RATE_UNITY;
            end else begin
              divisor_nxt = TIME_W'(gain_diff);
              div_rem_nxt = '0;
              div_q_nxt   = '0;
            end
          end
          MODE_STOP: begin
            active_nxt      = 1'b0;
            start_level_nxt = set_r;
            end_level_nxt   = set_r;
          end
          default: begin
            // unknown mode: report the state as it stands
            done_nxt = 1'b0;
          end
        endcase
      end
      ST_MUL: begin
        acc_nxt = mul_sum[RATE_W:1];
        plo_nxt = {mul_sum[0], plo_r[TIME_W-1:1]};
        dt_nxt  = {1'b0, dt_r[TIME_W-1:1]};
        cnt_nxt = cnt_r + 1'b1;
      end
      ST_TICK: begin
        // saturate at the length and flag completion once
        if (tick_end) begin
          elapsed_nxt = fade_length_r;
          active_nxt  = 1'b0;
          done_nxt    = 1'b1;
        end else begin
          elapsed_nxt = tick_sum[TIME_W-1:0];
        end
      end
      ST_RDIV: begin
        div_rem_nxt = rem_next;
        div_q_nxt   = q_next;
        cnt_nxt     = cnt_r + 1'b1;
        if (rdiv_last) begin
          rate_scale_nxt = q_next;
          active_nxt     = 1'b1;
        end
      end
      ST_GAIN: begin
        priority if (!active_r) begin
          cur_nxt = end_level_r;
        end else if (prog_full) begin
          p_nxt = ONE_Q16;
        end else begin
          div_rem_nxt = elapsed_r;
          divisor_nxt = fade_length_r;
          div_q_nxt   = '0;
          cnt_nxt     = '0;
        end
      end
      ST_PDIV: begin
        div_rem_nxt = rem_next;
        div_q_nxt   = q_next;
        cnt_nxt     = cnt_r + 1'b1;
        if (pdiv_last) p_nxt = {1'b0, q_next[FRAC_W-1:0]};
      end
      ST_POS: begin
        pos_nxt = POS_W'(p_r) * POS_W'(COS_TABLE_DEPTH);
      end
      ST_TAB: begin
        lo_nxt  = cos_tab[lo_idx];
        hi_nxt  = cos_tab[hi_idx];
        sat_nxt = tab_sat;
      end
      ST_INTERP: begin
        unique case (curve_kind_r)
          CURVE_LINEAR: w_nxt = p_r;
          CURVE_COSINE: w_nxt = (sat_r || (hi_r < lo_r)) ? lo_r : lerp;
          default:      w_nxt = ONE_Q16;
        endcase
        up_nxt = end_level_r >= start_level_r;
      end
      ST_BLEND: begin
        m_nxt = blend_prod[FRAC_W+GAIN_W-1:FRAC_W];
      end
      ST_SUM: begin
        cur_nxt = up_r ? start_level_r + m_r : start_level_r - m_r;
      end
      ST_OUT: begin
        // hold until the output register is free, then load it
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_gain_nxt   = cur_r;
          out_done_nxt   = done_r;
          out_fading_nxt = active_r;
          out_target_nxt = end_level_r;
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control and fade state registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      start_level_r <= '0;
      end_level_r   <= '0;
      elapsed_r     <= '0;
      rate_scale_r  <= RATE_UNITY;
      active_r      <= 1'b0;
      done_r        <= 1'b0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      start_level_r <= start_level_nxt;
      end_level_r   <= end_level_nxt;
      elapsed_r     <= elapsed_nxt;
      rate_scale_r  <= rate_scale_nxt;
      active_r      <= active_nxt;
      done_r        <= done_nxt;
      cnt_r         <= cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    dt_r         <= dt_nxt;
    from_r       <= from_nxt;
    to_r         <= to_nxt;
    set_r        <= set_nxt;
    acc_r        <= acc_nxt;
    plo_r        <= plo_nxt;
    div_rem_r    <= div_rem_nxt;
    divisor_r    <= divisor_nxt;
    div_q_r      <= div_q_nxt;
    p_r          <= p_nxt;
    pos_r        <= pos_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    sat_r        <= sat_nxt;
    w_r          <= w_nxt;
    up_r         <= up_nxt;
    m_r          <= m_nxt;
    cur_r        <= cur_nxt;
    out_gain_r   <= out_gain_nxt;
    out_done_r   <= out_done_nxt;
    out_fading_r <= out_fading_nxt;
    out_target_r <= out_target_nxt;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_done_ends_fade: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> !out_fading_r)
    else $error("completion reported while still fading");

  a_rate_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (rate_scale_r <= RATE_MAX))
    else $error("time scale out of range during a fade");

  a_progress_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POS) |-> (p_r <= ONE_Q16))
    else $error("progress above one");

  a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (cnt_r < CNT_W'(MUL_STEPS)))
    else $error("serial multiply ran past its last step");

  a_result_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not loaded into the output register");

endmodule

// File: sim/gain_fade_ramp_top_test.sv
// ----------------------------------------------------------------------------
// gain_fade_ramp_top_test: self-checking bench for the gain fade ramp
// Send start, tick, stop and unknown commands in random bursts while the
// result side stalls in a pattern of its own. Predict each result with a
// local fade model, compare it with the oldest pending prediction, and
// reprogram fade length and curve between phases while the block is quiet.
// ----------------------------------------------------------------------------
module gain_fade_ramp_top_test;
  import gfr_pkg::*;

  localparam logic [1:0] MODE_UNKNOWN  = 2'd3;
  localparam logic [1:0] CURVE_UNKNOWN = 2'd3;

  localparam logic [TIME_W-1:0] DT_MAX   = '1;
  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
  localparam int FADE_SPAN_MIN = 66;

  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 150;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 80;
  localparam int RUN_LIMIT    = 2400000;

  // Receiver stall patterns
  localparam int STALL_NONE     = 0;
  localparam int STALL_RANDOM   = 1;
  localparam int STALL_PERIODIC = 2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [TIME_W-1:0] dt;
    logic [GAIN_W-1:0] from_gain;
    logic [GAIN_W-1:0] to_gain;
    logic [GAIN_W-1:0] set_gain;
  } fade_cmd_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic              done;
    logic              fading;
    logic [GAIN_W-1:0] target;
  } gain_report_t;

  logic                  clk;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_mode      = MODE_TICK;
  logic [TIME_W-1:0]     in_dt        = '0;
  logic [GAIN_W-1:0]     in_from_gain = '0;
  logic [GAIN_W-1:0]     in_to_gain   = '0;
  logic [GAIN_W-1:0]     in_set_gain  = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [GAIN_W-1:0]     out_current_gain;
  logic                  out_fade_done;
  logic                  out_is_fading;
  logic [GAIN_W-1:0]     out_target_gain;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr        = '0;
  logic [31:0]           pwdata       = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // Fade model: register copies and state
  logic [TIME_W-1:0] fade_len    = '0;
  logic [1:0]        curve       = CURVE_NONE;
  logic [GAIN_W-1:0] from_lvl    = '0;
  logic [GAIN_W-1:0] to_lvl      = '0;
  logic [31:0]       elapsed_q16 = '0;
  logic [RATE_W-1:0] time_scale  = RATE_UNITY;
  logic              fading      = 1'b0;
  logic [GAIN_W-1:0] rc_tab [0:COS_TABLE_DEPTH];

  fade_cmd_t    cmd_q[$];
  gain_report_t pending_reports[$];
  int mismatches = 0;
  bit in_xfer    = 1'b0;
  int burst_left = 0;
  int gap_left   = 0;
  int stall_left = 0;
  int stall_kind = STALL_NONE;

  gain_fade_ramp_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_dt            (in_dt),
    .in_from_gain     (in_from_gain),
    .in_to_gain       (in_to_gain),
    .in_set_gain      (in_set_gain),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_current_gain (out_current_gain),
    .out_fade_done    (out_fade_done),
    .out_is_fading    (out_is_fading),
    .out_target_gain  (out_target_gain),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // One Horner step of the cosine series: 1 - min(1, a^2 * c / den), Q30
  function automatic logic [63:0] cos_series_step(input logic [63:0] c,
                                                  input logic [63:0] ang2,
                                                  input logic [63:0] den);
    logic [63:0] t;
    t = ((ang2 * c) >> 30) / den;
    return (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
  endfunction

  // Raised cosine at table point i of the lower half, Q16
  function automatic logic [GAIN_W-1:0] rc_point(input int unsigned i);
    logic [63:0] ang;
    logic [63:0] ang2;
    logic [63:0] c;
    ang  = (PI_Q30 * 64'(i)) / 64'(COS_TABLE_DEPTH);
    ang2 = (ang * ang) >> 30;
    c = cos_series_step(ONE_Q30, ang2, 64'd132);
    c = cos_series_step(c, ang2, 64'd90);
    c = cos_series_step(c, ang2, 64'd56);
    c = cos_series_step(c, ang2, 64'd30);
    c = cos_series_step(c, ang2, 64'd12);
    c = cos_series_step(c, ang2, 64'd2);
    return GAIN_W'(((ONE_Q30 - c) + 64'd16384) >> 15);
  endfunction

  // Curve weight in Q1.16 for the current progress
  function automatic logic [63:0] fade_weight();
    logic [63:0] p;
    logic [63:0] pos;
    logic [63:0] frac;
    logic [63:0] lo;
    logic [63:0] hi;
    int idx;
    if (fade_len == '0) begin
      p = 64'(ONE_Q16);
    end else begin
      p = (64'(elapsed_q16) << 16) / 64'(fade_len);
      if (p > 64'(ONE_Q16)) p = 64'(ONE_Q16);
    end
    case (curve)
      CURVE_LINEAR: begin
        return p;
      end
      CURVE_COSINE: begin
        pos  = p * COS_TABLE_DEPTH;
        idx  = int'(pos >> FRAC_W);
        frac = pos & 64'hFFFF;
        if (idx >= COS_TABLE_DEPTH) return 64'(rc_tab[COS_TABLE_DEPTH]);
        lo = 64'(rc_tab[idx]);
        hi = 64'(rc_tab[idx + 1]);
        if (hi < lo) return lo;
        return lo + (((hi - lo) * frac) >> 16);
      end
      default: begin
        return 64'(ONE_Q16);
      end
    endcase
  endfunction

  // Advance the fade model by one command and form the result it reports
  function automatic gain_report_t step_fade(input fade_cmd_t c);
    logic [63:0] sum;
    logic [63:0] span;
    logic [63:0] w;
    logic [63:0] move;
    gain_report_t r;
    r = '0;
    case (c.mode)
      MODE_TICK: begin
        if (fading) begin
          sum = 64'(elapsed_q16) + ((64'(c.dt) * 64'(time_scale)) >> 16);
          if (sum >= 64'(fade_len)) begin
            elapsed_q16 = 32'(fade_len);
            fading      = 1'b0;
            r.done      = 1'b1;
          end else begin
            elapsed_q16 = sum[31:0];
          end
        end
      end
      MODE_START: begin
        from_lvl    = c.from_gain;
        to_lvl      = c.to_gain;
        elapsed_q16 = '0;
        span = (c.from_gain > c.to_gain) ? 64'(c.from_gain - c.to_gain)
                                         : 64'(c.to_gain - c.from_gain);
        // Spans under 0.001 do not fade at all
        if (span * 64'd1000 < 64'(ONE_Q16)) begin
          fading     = 1'b0;
          time_scale = RATE_UNITY;
        end else begin
          fading     = 1'b1;
          time_scale = RATE_W'(64'h1_0000_0000 / span);
        end
      end
      MODE_STOP: begin
        fading   = 1'b0;
        from_lvl = c.set_gain;
        to_lvl   = c.set_gain;
      end
      default: begin
        // unknown mode: report the state untouched
      end
    endcase
    r.fading = fading;
    r.target = to_lvl;
    r.gain   = to_lvl;
    if (fading) begin
      w = fade_weight();
      if (to_lvl >= from_lvl) begin
        move   = (64'(to_lvl - from_lvl) * w + 64'd32768) >> 16;
        r.gain = from_lvl + GAIN_W'(move);
      end else begin
        move   = (64'(from_lvl - to_lvl) * w + 64'd32768) >> 16;
        r.gain = from_lvl - GAIN_W'(move);
      end
    end
    return r;
  endfunction

  task automatic log_mismatch(input string what, input gain_report_t want,
                              input gain_report_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t %s: gain %0d/%0d done %0d/%0d fading %0d/%0d target %0d/%0d",
               $time, what, want.gain, got.gain, want.done, got.done,
               want.fading, got.fading, want.target, got.target);
    end
  endtask

  // Sample both channels at the rising edge: check a result transfer against
  // the oldest prediction first, then predict for a command transfer.
  always @(posedge clk) begin : result_monitor
    fade_cmd_t    c;
    gain_report_t got;
    gain_report_t want;
    in_xfer = in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.gain   = out_current_gain;
        got.done   = out_fade_done;
        got.fading = out_is_fading;
        got.target = out_target_gain;
        if (pending_reports.size() == 0) begin
          log_mismatch("result with nothing pending (expected/actual)", '0, got);
        end else begin
          want = pending_reports.pop_front();
          if (got.gain != want.gain || got.done != want.done ||
              got.fading != want.fading || got.target != want.target) begin
            log_mismatch("result mismatch (expected/actual)", want, got);
          end
        end
      end
      if (in_xfer) begin
        c.mode      = in_mode;
        c.dt        = in_dt;
        c.from_gain = in_from_gain;
        c.to_gain   = in_to_gain;
        c.set_gain  = in_set_gain;
        pending_reports.push_back(step_fade(c));
      end
    end
  end

  // Command driver: hold a stalled transfer, otherwise send the next queued
  // command in bursts of random length separated by random gaps.
  always @(negedge clk) begin : cmd_driver
    fade_cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_xfer) begin
      // hold the payload until the block takes it
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (cmd_q.size() > 0) begin
      c = cmd_q.pop_front();
      in_mode      <= c.mode;
      in_dt        <= c.dt;
      in_from_gain <= c.from_gain;
      in_to_gain   <= c.to_gain;
      in_set_gain  <= c.set_gain;
      in_valid     <= 1'b1;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result stall: segments of no stall, coin-flip stall, or a 5-of-8 pattern
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(8, 64);
      stall_kind = $urandom_range(STALL_NONE, STALL_PERIODIC);
    end
    stall_left--;
    case (stall_kind)
      STALL_NONE: begin
        out_stall <= 1'b0;
      end
      STALL_RANDOM: begin
        out_stall <= 1'($urandom_range(0, 1));
      end
      default: begin
        out_stall <= (stall_left % 8) < 5;
      end
    endcase
  end

  task automatic push_cmd(input logic [1:0] mode, input logic [TIME_W-1:0] dt,
                          input logic [GAIN_W-1:0] from_g,
                          input logic [GAIN_W-1:0] to_g,
                          input logic [GAIN_W-1:0] set_g);
    fade_cmd_t c;
    c.mode      = mode;
    c.dt        = dt;
    c.from_gain = from_g;
    c.to_gain   = to_g;
    c.set_gain  = set_g;
    cmd_q.push_back(c);
  endtask

  // Mostly gains up to unity, now and then anything the field holds
  function automatic logic [GAIN_W-1:0] rand_gain();
    if ($urandom_range(0, 7) == 0) return GAIN_W'($urandom_range(0, GAIN_MAX));
    return GAIN_W'($urandom_range(0, ONE_Q16));
  endfunction

  task automatic push_noise();
    push_cmd(2'($urandom_range(0, 3)), TIME_W'($urandom),
             GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom));
  endtask

  // A start followed by ticks sized to finish the fade in about n steps
  task automatic push_fade_run(output int count);
    logic [GAIN_W-1:0] a;
    logic [GAIN_W-1:0] b;
    logic [63:0] span;
    logic [63:0] dt_hi;
    int n;
    a = rand_gain();
    b = rand_gain();
    if ($urandom_range(0, 9) != 0) begin
      while (((a > b) ? a - b : b - a) < FADE_SPAN_MIN) b = rand_gain();
    end
    span  = (a > b) ? 64'(a - b) : 64'(b - a);
    n     = $urandom_range(1, 24);
    dt_hi = (64'(fade_len) * span * 64'd2) / (64'd65536 * 64'(n));
    if (dt_hi > 64'(DT_MAX)) dt_hi = 64'(DT_MAX);
    push_cmd(MODE_START, TIME_W'($urandom), a, b, GAIN_W'($urandom));
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 15))
        0: begin
          push_noise();
        end
        1: begin
          push_cmd(MODE_TICK, TIME_W'($urandom), rand_gain(), rand_gain(), rand_gain());
        end
        default: begin
          push_cmd(MODE_TICK, TIME_W'($urandom_range(0, 32'(dt_hi))),
                   rand_gain(), rand_gain(), rand_gain());
        end
      endcase
    end
    count = n + 1;
  endtask

  // Wait until every command is sent and every result has come back
  task automatic wait_quiet();
    @(posedge clk);
    while (cmd_q.size() != 0 || in_valid || pending_reports.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Register write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic sel, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (sel == REG_FADE_LENGTH) begin
      fade_len = value[TIME_W-1:0];
    end else begin
      curve = value[1:0];
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : stimulus
    int queued;
    int run_len;
    for (int i = 0; i <= COS_TABLE_DEPTH; i++) begin
      rc_tab[i] = (2 * i <= COS_TABLE_DEPTH) ? rc_point(i)
                                              : ONE_Q16 - rc_point(COS_TABLE_DEPTH - i);
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset registers: idle tick, unknown mode, stop at unity, equal gains
    push_cmd(MODE_TICK, DT_MAX, '0, '0, '0);
    push_cmd(MODE_UNKNOWN, DT_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
    push_cmd(MODE_STOP, '0, '0, '0, ONE_Q16);
    push_cmd(MODE_START, '0, 17'd5, 17'd5, '0);
    wait_quiet();

    // One second linear fade 0 to unity in four quarter steps, tick past end
    write_reg(REG_FADE_LENGTH, 32'd65536);
    write_reg(REG_CURVE_KIND, 32'(CURVE_LINEAR));
    push_cmd(MODE_START, '0, '0, ONE_Q16, '0);
    push_cmd(MODE_TICK, 24'd16384, '0, '0, '0);
    push_cmd(MODE_TICK, 24'd16384, '0, '0, '0);
    push_cmd(MODE_UNKNOWN, '0, '0, '0, '0);
    push_cmd(MODE_TICK, 24'd16384, '0, '0, '0);
    push_cmd(MODE_TICK, 24'd16384, '0, '0, '0);
    push_cmd(MODE_TICK, '0, '0, '0, '0);
    wait_quiet();

    // Longest length, cosine: downward fade, spans just below and at the
    // fade threshold, largest step, and a fade left running above unity
    write_reg(REG_CURVE_KIND, 32'(CURVE_COSINE));
    write_reg(REG_FADE_LENGTH, 32'(DT_MAX));
    push_cmd(MODE_START, '0, ONE_Q16, '0, '0);
    push_cmd(MODE_TICK, 24'd1, '0, '0, '0);
    push_cmd(MODE_TICK, 24'h800000, '0, '0, '0);
    push_cmd(MODE_START, '0, 17'd1000, 17'd1065, '0);
    push_cmd(MODE_START, '0, 17'd1000, 17'd1066, '0);
    push_cmd(MODE_TICK, 24'd1, '0, '0, '0);
    push_cmd(MODE_TICK, DT_MAX, '0, '0, '0);
    push_cmd(MODE_START, '0, GAIN_MAX, '0, '0);
    push_cmd(MODE_TICK, 24'd100, '0, '0, '0);
    wait_quiet();

    // Shorten the length under the running fade, unknown curve: progress
    // clamps, and the next tick completes even with a zero step
    write_reg(REG_FADE_LENGTH, 32'd1);
    write_reg(REG_CURVE_KIND, 32'(CURVE_UNKNOWN));
    push_cmd(MODE_UNKNOWN, '0, '0, '0, '0);
    push_cmd(MODE_TICK, '0, '0, '0, '0);
    push_cmd(MODE_STOP, '0, '0, '0, '0);
    wait_quiet();

    // Zero length: progress is full at once
    write_reg(REG_FADE_LENGTH, 32'd0);
    write_reg(REG_CURVE_KIND, 32'(CURVE_LINEAR));
    push_cmd(MODE_START, '0, 17'd70000, 17'd200, '0);
    push_cmd(MODE_TICK, 24'd5, '0, '0, '0);

    // Random phases, each under a fresh length and curve
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_quiet();
      case ($urandom_range(0, 7))
        0:       write_reg(REG_FADE_LENGTH, 32'd0);
        1:       write_reg(REG_FADE_LENGTH, 32'd1);
        2:       write_reg(REG_FADE_LENGTH, 32'(DT_MAX));
        3, 4:    write_reg(REG_FADE_LENGTH, $urandom_range(16, 262144));
        default: write_reg(REG_FADE_LENGTH, $urandom_range(1, DT_MAX));
      endcase
      case ($urandom_range(0, 5))
        0:       write_reg(REG_CURVE_KIND, 32'(CURVE_NONE));
        1, 2:    write_reg(REG_CURVE_KIND, 32'(CURVE_LINEAR));
        3, 4:    write_reg(REG_CURVE_KIND, 32'(CURVE_COSINE));
        default: write_reg(REG_CURVE_KIND, 32'(CURVE_UNKNOWN));
      endcase
      queued = 0;
      while (queued < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) == 0) begin
          push_noise();
          queued++;
        end else begin
          push_fade_run(run_len);
          queued += run_len;
        end
      end
    end

    // Drain, then allow for a stray late result
    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("simulation failed");
    $finish;
  end

endmodule
